FILE: rtl/ntc_pkg.sv
`default_nettype none
package ntc_pkg;

  localparam int RailMarginDef = 10;
  localparam int LogEntriesDef = 256;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgBeta    = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgNominal = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPullup  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSupply  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTemp0   = 3'd4;

  // status codes
  localparam logic [1:0] StatOk     = 2'd0;
  localparam logic [1:0] StatBadCfg = 2'd1;
  localparam logic [1:0] StatRail   = 2'd2;

  localparam logic [15:0] BetaRst    = 16'd3950;
  localparam logic [19:0] NominalRst = 20'd10000;
  localparam logic [19:0] PullupRst  = 20'd10000;
  localparam logic [12:0] SupplyRst  = 13'd3300;
  localparam logic [18:0] Temp0Rst   = 19'd298150;

  localparam logic [27:0] Ln2Q28 = 28'd186065280;
  localparam logic [49:0] InvNum = 50'd1000 << 40;   // 1000 * 2^40
  localparam logic [50:0] TckNum = 51'd100 << 40;    // 100 * 2^40
  localparam logic [17:0] CkMax  = 18'd92850;        // 655.35 C in centikelvin
  localparam logic [17:0] ZeroCk = 18'd27315;
  localparam logic signed [16:0] TempMin = -17'sd27315;
  localparam logic signed [16:0] TempMax = 17'sd65535;

  // flags that travel with a request down the pipe
  typedef struct packed {
    logic [1:0] status;
    logic       sat;       // ratio clipped to all ones
    logic       zero;      // ratio of zero
    logic       inv_neg;   // 1/T below zero
    logic       inv_zero;  // 1/T of zero
    logic       ovf;       // centikelvin quotient out of range
  } ntc_side_t;

  // log2(1 + i/n) in Q.30, by truncating bitwise squaring (elaboration only)
  function automatic logic [30:0] ntc_log2_entry(input int unsigned i, input int unsigned n);
    logic [63:0] num;
    logic [63:0] r;
    logic [63:0] y;
    logic [30:0] res;
    num = 64'(i + n) << 30;
    r   = '0;
    y   = '0;
    res = '0;
    for (int k = 63; k >= 0; k--) begin
      r = {r[62:0], num[k]};
      if (r >= 64'(n)) begin
        r    = r - 64'(n);
        y[k] = 1'b1;
      end
    end
    if (y >= 64'h8000_0000) begin
      y       = y >> 1;
      res[30] = 1'b1;
    end
    for (int b = 29; b >= 0; b--) begin
      y = (y * y) >> 30;
      if (y >= 64'h8000_0000) begin
        y      = y >> 1;
        res[b] = 1'b1;
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ntc_beta_temperature_top.sv
`default_nettype none
// NTC thermistor temperature by the beta equation. Each request carries one
// divider pin reading in mV; its result leaves the end of the pipeline as a
// single-cycle done pulse with temp_centi_c (centidegrees C) and status
// (ok, bad configuration, rail fault). The pipeline takes a new request on
// every clock (busy stays low), so a full result stream arrives one per
// cycle; the receiver cannot stall it and must take each result as it comes.
// Most of the pipeline depth lies in the bit-serial pipelined dividers: 32 stages
// for the resistance ratio, 50 for ln/beta and 1/T0 side by side, and 18 for
// the final reciprocal. Write configuration registers only while no request
// is in flight.
module ntc_beta_temperature_top #(
  parameter int RAIL_MARGIN_MV    = ntc_pkg::RailMarginDef,
  parameter int LOG_TABLE_ENTRIES = ntc_pkg::LogEntriesDef
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [ntc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ntc_pkg::CfgDataW-1:0] cfg_data,
  input  logic                         start,
  input  logic [12:0]                  pin_mv,
  output logic                         busy,
  output logic                         done,
  output logic signed [16:0]           temp_centi_c,
  output logic [1:0]                   status
);
  import ntc_pkg::*;

  localparam logic [13:0] MarginMv = 14'(RAIL_MARGIN_MV);
  localparam int SideW = $bits(ntc_side_t);

  // configuration registers
  logic [15:0] beta_kelvin;
  logic [19:0] nominal_ohms;
  logic [19:0] pullup_ohms;
  logic [12:0] supply_mv;
  logic [18:0] nominal_temp_mk;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta_kelvin     <= BetaRst;
      nominal_ohms    <= NominalRst;
      pullup_ohms     <= PullupRst;
      supply_mv       <= SupplyRst;
      nominal_temp_mk <= Temp0Rst;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgBeta:    beta_kelvin     <= cfg_data[15:0];
        CfgNominal: nominal_ohms    <= cfg_data;
        CfgPullup:  pullup_ohms     <= cfg_data;
        CfgSupply:  supply_mv       <= cfg_data[12:0];
        CfgTemp0:   nominal_temp_mk <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  // Fully pipelined: never refuses a request.
  assign busy = 1'b0;

  // ---- T0: capture request, decide status ----
  logic        take;
  logic [1:0]  status_c;
  logic        t0_v;
  logic [12:0] t0_pin;
  logic [1:0]  t0_status;

  assign take = start & ~busy;

  always_comb begin
    if (beta_kelvin == '0 || nominal_ohms == '0 || pullup_ohms == '0 || supply_mv == '0) begin
      status_c = StatBadCfg;
    end else if ({1'b0, pin_mv} <= MarginMv ||
                 {1'b0, pin_mv} + MarginMv >= {1'b0, supply_mv}) begin
      status_c = StatRail;   // open or shorted divider, or pin above supply
    end else begin
      status_c = StatOk;
    end
  end

  // ---- T1: numerator and denominator products ----
  logic        t1_v;
  logic [32:0] t1_pn;    // pullup * V
  logic [32:0] t1_pd;    // (Vcc - V) * R0
  logic [1:0]  t1_status;

  // ---- T2: saturation check, divider load ----
  logic        sat_c;
  ntc_side_t   side2_c;
  logic        t2_v;
  logic [32:0] t2_rem;
  logic [31:0] t2_num;
  logic [32:0] t2_den;
  ntc_side_t   t2_side;

  // ratio >= 2^32 when the part of the numerator above bit 32 reaches den
  assign sat_c = {16'b0, t1_pn[32:16]} >= t1_pd;

  always_comb begin
    side2_c        = '0;
    side2_c.status = t1_status;
    side2_c.sat    = sat_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t0_v <= 1'b0;
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else begin
      t0_v <= take;
      t1_v <= t0_v;
      t2_v <= t1_v;
    end
    t0_pin    <= pin_mv;
    t0_status <= status_c;

    t1_pn     <= 33'(pullup_ohms) * 33'(t0_pin);
    t1_pd     <= 33'(supply_mv - t0_pin) * 33'(nominal_ohms);
    t1_status <= t0_status;

    t2_rem  <= sat_c ? '0 : {16'b0, t1_pn[32:16]};
    t2_num  <= {t1_pn[15:0], 16'b0};
    t2_den  <= t1_pd;
    t2_side <= side2_c;
  end

  // ---- ratio divider, Q16.16 ----
  logic        d1_v;
  logic [31:0] d1_quo;
  ntc_side_t   d1_side;

  ntc_div_pipe #(.DEN_W(33), .QUO_W(32), .SIDE_W(SideW)) u_div_ratio (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t2_v),
    .in_rem   (t2_rem),
    .in_num   (t2_num),
    .in_den   (t2_den),
    .in_side  (t2_side),
    .out_valid(d1_v),
    .out_quo  (d1_quo),
    .out_side (d1_side)
  );

  // ---- T3: clip ratio, flag zero ----
  logic [31:0] ratio_c;
  ntc_side_t   side3_c;
  logic        t3_v;
  logic [31:0] t3_ratio;
  ntc_side_t   t3_side;

  assign ratio_c = d1_side.sat ? '1 : d1_quo;

  always_comb begin
    side3_c      = d1_side;
    side3_c.zero = (ratio_c == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_v <= 1'b0;
    end else begin
      t3_v <= d1_v;
    end
    t3_ratio <= ratio_c;
    t3_side  <= side3_c;
  end

  // ---- log2 ----
  logic        lg_v;
  logic [34:0] lg_mag;
  logic        lg_neg;
  ntc_side_t   lg_side;

  ntc_log2 #(.ENTRIES(LOG_TABLE_ENTRIES)) u_log2 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t3_v),
    .in_ratio (t3_ratio),
    .in_side  (t3_side),
    .out_valid(lg_v),
    .out_mag  (lg_mag),
    .out_neg  (lg_neg),
    .out_side (lg_side)
  );

  // ---- T4: to natural log, Q.40 ----
  logic [62:0] ln_prod;
  logic        t4_v;
  logic [44:0] t4_x;
  logic [18:0] t4_t0;
  logic        t4_neg;
  ntc_side_t   t4_side;

  assign ln_prod = 63'(lg_mag) * 63'(Ln2Q28);

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_v <= 1'b0;
    end else begin
      t4_v <= lg_v;
    end
    t4_x    <= ln_prod[62:18];
    t4_t0   <= (nominal_temp_mk == '0) ? 19'd1 : nominal_temp_mk;  // zero T0 taken as 1
    t4_neg  <= lg_neg;
    t4_side <= lg_side;
  end

  // ---- ln/beta and 1/T0 dividers, same depth ----
  logic        dt_v;
  logic [49:0] dt_quo;
  ntc_side_t   dt_side;
  logic        dv_v;
  logic [49:0] dv_quo;
  logic        dv_neg;

  ntc_div_pipe #(.DEN_W(16), .QUO_W(50), .SIDE_W(SideW)) u_div_term (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t4_v),
    .in_rem   ('0),
    .in_num   ({5'b0, t4_x}),
    .in_den   (beta_kelvin),
    .in_side  (t4_side),
    .out_valid(dt_v),
    .out_quo  (dt_quo),
    .out_side (dt_side)
  );

  ntc_div_pipe #(.DEN_W(19), .QUO_W(50), .SIDE_W(1)) u_div_inv0 (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t4_v),
    .in_rem   ('0),
    .in_num   (InvNum),
    .in_den   (t4_t0),
    .in_side  (t4_neg),
    .out_valid(dv_v),
    .out_quo  (dv_quo),
    .out_side (dv_neg)
  );

  // ---- T6: 1/T = 1/T0 +- ln/beta ----
  logic signed [51:0] inv_c;
  logic               t6_v;
  logic signed [51:0] t6_inv;
  ntc_side_t          t6_side;

  assign inv_c = dv_neg ? $signed({2'b0, dv_quo}) - $signed({2'b0, dt_quo})
                        : $signed({2'b0, dv_quo}) + $signed({2'b0, dt_quo});

  // ---- T7: rounded reciprocal setup ----
  logic [50:0] inv_u;
  logic [50:0] tnum_c;
  logic        ovf_c;
  ntc_side_t   side7_c;
  logic        t7_v;
  logic [50:0] t7_rem;
  logic [17:0] t7_num;
  logic [50:0] t7_den;
  ntc_side_t   t7_side;

  assign inv_u  = t6_inv[50:0];
  assign tnum_c = TckNum + {1'b0, inv_u[50:1]};
  assign ovf_c  = 51'(tnum_c[50:18]) >= inv_u;   // quotient of 2^18 or more

  always_comb begin
    side7_c          = t6_side;
    side7_c.inv_neg  = t6_inv[51];
    side7_c.inv_zero = (t6_inv == '0);
    side7_c.ovf      = ovf_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_v <= 1'b0;
      t7_v <= 1'b0;
    end else begin
      t6_v <= dt_v & dv_v;
      t7_v <= t6_v;
    end
    t6_inv  <= inv_c;
    t6_side <= dt_side;

    t7_rem  <= ovf_c ? '0 : 51'(tnum_c[50:18]);
    t7_num  <= tnum_c[17:0];
    t7_den  <= inv_u;
    t7_side <= side7_c;
  end

  // ---- centikelvin divider ----
  logic        dk_v;
  logic [17:0] dk_quo;
  ntc_side_t   dk_side;

  ntc_div_pipe #(.DEN_W(51), .QUO_W(18), .SIDE_W(SideW)) u_div_tck (
    .clk      (clk),
    .rst      (rst),
    .in_valid (t7_v),
    .in_rem   (t7_rem),
    .in_num   (t7_num),
    .in_den   (t7_den),
    .in_side  (t7_side),
    .out_valid(dk_v),
    .out_quo  (dk_quo),
    .out_side (dk_side)
  );

  // ---- T8: saturate and present ----
  logic signed [18:0] tdiff_c;
  logic signed [16:0] temp_c;

  assign tdiff_c = $signed({1'b0, dk_quo}) - $signed({1'b0, ZeroCk});

  always_comb begin
    if (dk_side.status != StatOk) begin
      temp_c = '0;
    end else if (dk_side.zero || dk_side.inv_neg) begin
      temp_c = TempMin;
    end else if (dk_side.inv_zero || dk_side.ovf || dk_quo > CkMax) begin
      temp_c = TempMax;
    end else begin
      temp_c = tdiff_c[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dk_v;
    end
    temp_centi_c <= temp_c;
    status       <= dk_side.status;
  end

endmodule
`default_nettype wire

FILE: rtl/ntc_div_pipe.sv
`default_nettype none
// Restoring divider, one quotient bit per register stage.
// Requires in_rem < in_den; quotient is {in_rem, in_num} / in_den.
module ntc_div_pipe #(
  parameter int DEN_W  = 33,
  parameter int QUO_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [QUO_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QUO_W-1:0]  out_quo,
  output logic [SIDE_W-1:0] out_side
);

  logic              vld_q  [QUO_W];
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  acc_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];

  for (genvar s = 0; s < QUO_W; s++) begin : g_stg
    logic              cur_vld;
    logic [DEN_W-1:0]  cur_rem;
    logic [QUO_W-1:0]  cur_acc;
    logic [DEN_W-1:0]  cur_den;
    logic [SIDE_W-1:0] cur_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;

    if (s == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = in_rem;
      assign cur_acc  = in_num;
      assign cur_den  = in_den;
      assign cur_side = in_side;
    end else begin : g_rest
      assign cur_vld  = vld_q[s-1];
      assign cur_rem  = rem_q[s-1];
      assign cur_acc  = acc_q[s-1];
      assign cur_den  = den_q[s-1];
      assign cur_side = side_q[s-1];
    end

    assign trial = {cur_rem, cur_acc[QUO_W-1]};
    assign diff  = trial - {1'b0, cur_den};
    assign fits  = trial >= {1'b0, cur_den};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= cur_vld;
      end
      rem_q[s]  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      acc_q[s]  <= {cur_acc[QUO_W-2:0], fits};
      den_q[s]  <= cur_den;
      side_q[s] <= cur_side;
    end
  end

  assign out_valid = vld_q[QUO_W-1];
  assign out_quo   = acc_q[QUO_W-1];
  assign out_side  = side_q[QUO_W-1];

endmodule
`default_nettype wire

FILE: rtl/ntc_log2.sv
`default_nettype none
// log2 of a Q16.16 ratio, returned as magnitude (Q.30) and sign. Five stages.
module ntc_log2 #(
  parameter int ENTRIES = ntc_pkg::LogEntriesDef
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [31:0]       in_ratio,
  input  ntc_pkg::ntc_side_t in_side,
  output logic              out_valid,
  output logic [34:0]       out_mag,
  output logic              out_neg,
  output ntc_pkg::ntc_side_t out_side
);
  import ntc_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int SC_W  = 31 + IDX_W;

  logic [30:0] lo_tab [ENTRIES];
  logic [30:0] hi_tab [ENTRIES];

  for (genvar g = 0; g < ENTRIES; g++) begin : g_tab
    localparam logic [30:0] LoVal = ntc_log2_entry(g, ENTRIES);
    localparam logic [30:0] HiVal = ntc_log2_entry(g + 1, ENTRIES);
    assign lo_tab[g] = LoVal;
    assign hi_tab[g] = HiVal;
  end

  // stage 1: leading one
  logic [4:0]  p_c;
  logic        s1_v;
  logic [31:0] s1_ratio;
  logic [4:0]  s1_p;
  ntc_side_t   s1_side;

  always_comb begin
    p_c = '0;
    for (int i = 0; i < 32; i++) begin
      if (in_ratio[i]) p_c = 5'(i);
    end
  end

  // stage 2: normalise, split into index and weight
  logic [31:0]      shifted;
  logic [SC_W-1:0]  scaled;
  logic             s2_v;
  logic [IDX_W-1:0] s2_idx;
  logic [30:0]      s2_rem;
  logic [4:0]       s2_p;
  ntc_side_t        s2_side;

  assign shifted = s1_ratio << (5'd31 - s1_p);
  assign scaled  = SC_W'(shifted[30:0]) * SC_W'(ENTRIES);

  // stage 3: table pair
  logic [30:0] lo_c;
  logic [30:0] hi_c;
  logic        s3_v;
  logic [30:0] s3_lo;
  logic [30:0] s3_delta;
  logic [30:0] s3_rem;
  logic [4:0]  s3_p;
  ntc_side_t   s3_side;

  assign lo_c = lo_tab[s2_idx];
  assign hi_c = hi_tab[s2_idx];

  // stage 4: interpolation product
  logic        s4_v;
  logic [61:0] s4_prod;
  logic [30:0] s4_lo;
  logic [4:0]  s4_p;
  ntc_side_t   s4_side;

  // stage 5: integer part joined with fraction
  logic [30:0] f_c;
  logic [34:0] mag_c;

  assign f_c = s4_lo + s4_prod[61:31];

  always_comb begin
    if (s4_p[4]) begin
      mag_c = {1'b0, s4_p[3:0], 30'b0} + 35'(f_c);
    end else begin
      mag_c = {5'd16 - s4_p, 30'b0} - 35'(f_c);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      s3_v      <= 1'b0;
      s4_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      s3_v      <= s2_v;
      s4_v      <= s3_v;
      out_valid <= s4_v;
    end
    s1_ratio <= in_ratio;
    s1_p     <= p_c;
    s1_side  <= in_side;

    s2_idx  <= scaled[SC_W-1:31];
    s2_rem  <= scaled[30:0];
    s2_p    <= s1_p;
    s2_side <= s1_side;

    s3_lo    <= lo_c;
    s3_delta <= (hi_c >= lo_c) ? hi_c - lo_c : '0;
    s3_rem   <= s2_rem;
    s3_p     <= s2_p;
    s3_side  <= s2_side;

    s4_prod <= 62'(s3_delta) * 62'(s3_rem);
    s4_lo   <= s3_lo;
    s4_p    <= s3_p;
    s4_side <= s3_side;

    out_mag  <= mag_c;
    out_neg  <= ~s4_p[4];
    out_side <= s4_side;
  end

endmodule
`default_nettype wire

FILE: rtl/ntc_chk.sv
`default_nettype none
module ntc_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [16:0] temp_centi_c,
  input logic [1:0]         status
);
  import ntc_pkg::*;

  // pipeline is flushed by reset
  a_reset_flush: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe after reset");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == StatOk || status == StatBadCfg || status == StatRail))
    else $error("undefined status code");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != StatOk) |-> temp_centi_c == '0)
    else $error("temperature not zero on fault");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && status == StatOk) |-> (temp_centi_c >= TempMin && temp_centi_c <= TempMax))
    else $error("temperature out of range");

  a_no_busy: assert property (@(posedge clk) disable iff (rst)
    start |-> !busy)
    else $error("request refused");

endmodule

bind ntc_beta_temperature_top ntc_chk u_chk (.*);
`default_nettype wire
